@@ hw/rtl/dabti_pkg.sv @@
package dabti_pkg;

   // Fixed branch structure of the DAB time interleaver
   localparam int BRANCHES = 16;
   localparam int SLOT_W   = 4;

   // Field widths
   localparam int VALUE_W = 16;
   localparam int CFG_W   = 14;

   // Fragment size after reset
   localparam int CFG_RESET = 64;

   typedef logic [SLOT_W-1:0] slot_type;

   // Branch delay index per position mod 16 (4-bit bit reversal)
   localparam slot_type BRANCH_MAP [BRANCHES] = '{
      4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
      4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
   };

endpackage

@@ hw/rtl/dabti_store.sv @@
module dabti_store #(
   parameter int ADDR_W = 17,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              access_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // One write and one read per enabled cycle; a read of the entry being written
   // returns the old contents.
   always_ff @(posedge clock) begin
      if (access_en) begin
         mem[wr_addr] <= wr_data;
         rd_data_ff   <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/dab_time_deinterleaver.sv @@
// DAB time deinterleaver, 16 branches. Soft values stream in one per cycle
// and leave one per cycle while rsp_ready does not stall them. Each response
// is held first in the delay memory read register, loaded as its request is
// accepted, then in the output register once that is free. Back pressure on
// rsp_ready stalls req_ready only once both the read register and the output
// register hold a value. The fragment length is set through
// csr_fragment_size (0 acts as 1, values above MAX_FRAGMENT act as
// MAX_FRAGMENT) and must only change while the block is idle. The first 16
// fragments only fill the delay memory and give no responses; after that
// every request gives exactly one response, with rsp_last_in_fragment marking
// the end of each fragment. All soft values live in one single-port-write,
// single-port-read RAM of 16 x MAX_FRAGMENT 16-bit words, which is not
// cleared after reset and needs no initialization pass.
module dab_time_deinterleaver #(
   parameter int MAX_FRAGMENT = 8192
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dabti_pkg::CFG_W-1:0]         csr_fragment_size,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [dabti_pkg::VALUE_W-1:0] req_soft_value,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dabti_pkg::VALUE_W-1:0] rsp_deinterleaved_value,
   output logic                                rsp_last_in_fragment
);

   import dabti_pkg::*;

   localparam int POS_W  = $clog2(MAX_FRAGMENT);
   localparam int ADDR_W = SLOT_W + POS_W;
   localparam int CNT_W  = (CFG_W > POS_W + 1) ? CFG_W : POS_W + 1;
   localparam int FILL_W = SLOT_W + 1;

   // Control and payload registers
   logic [CNT_W-1:0]   size_ff, size_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   slot_type           slot_ff, slot_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_last_ff;
   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_value_ff;
   logic               out_last_ff;

   logic               req_accept;
   logic               csr_accept;
   logic               filled;
   logic               s1_move;
   logic               last;
   logic [CNT_W-1:0]   pos_inc;
   logic [CNT_W-1:0]   cfg_ext;
   slot_type           rd_slot;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [VALUE_W-1:0] rd_data;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid & csr_ready;
   assign req_accept = req_valid & req_ready;
   assign filled     = fill_ff[FILL_W-1];

   // Fragment position bookkeeping
   assign pos_inc = CNT_W'(pos_ff) + CNT_W'(1);
   assign last    = (pos_inc >= size_ff);
   assign rd_slot = slot_ff + BRANCH_MAP[pos_ff[SLOT_W-1:0]];
   assign wr_addr = {slot_ff, pos_ff};
   assign rd_addr = {rd_slot, pos_ff};

   // Fragment size is clamped once, when written
   assign cfg_ext = CNT_W'(csr_fragment_size);

   always_comb begin
      size_in = size_ff;
      if (csr_accept) begin
         if (cfg_ext == '0) begin
            size_in = CNT_W'(1);
         end else if (cfg_ext > CNT_W'(MAX_FRAGMENT)) begin
            size_in = CNT_W'(MAX_FRAGMENT);
         end else begin
            size_in = cfg_ext;
         end
      end
   end

   // Position advances per request; slot and fill count advance at each fragment end
   always_comb begin
      pos_in  = pos_ff;
      slot_in = slot_ff;
      fill_in = fill_ff;
      if (req_accept) begin
         if (last) begin
            pos_in  = '0;
            slot_in = slot_ff + slot_type'(1);
            if (!filled) begin
               fill_in = fill_ff + FILL_W'(1);
            end
         end else begin
            pos_in = pos_inc[POS_W-1:0];
         end
      end
   end

   // Two-stage output: RAM read register, then output register
   assign s1_move   = s1_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | s1_move;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = filled;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= CNT_W'(CFG_RESET);
         pos_ff       <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         pos_ff       <= pos_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_last_ff <= last;
      end
      if (s1_move) begin
         out_value_ff <= rd_data;
         out_last_ff  <= s1_last_ff;
      end
   end

   // Delay memory: write current slot, read the branch-delayed slot
   dabti_store #(
      .ADDR_W (ADDR_W),
      .DATA_W (VALUE_W)
   ) u_store (
      .clock     (clock),
      .access_en (req_accept),
      .wr_addr   (wr_addr),
      .wr_data   (req_soft_value),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   assign rsp_valid               = out_valid_ff;
   assign rsp_deinterleaved_value = out_value_ff;
   assign rsp_last_in_fragment    = out_last_ff;

   // No response is produced while the store is still filling
   a_no_rsp_while_filling : assert property (@(posedge clock) disable iff (reset)
      req_accept && !filled |=> !s1_valid_ff)
      else $error("response staged before 16 fragments were absorbed");

   // Fill count saturates at 16
   a_fill_saturates : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(BRANCHES))
      else $error("fill count exceeded branch count");

   // A fragment end wraps the position and steps the slot
   a_fragment_wrap : assert property (@(posedge clock) disable iff (reset)
      req_accept && last |=> pos_ff == '0 && slot_ff == $past(slot_ff) + slot_type'(1))
      else $error("fragment end did not wrap position and advance slot");

   // A staged read value holds while the output side is stalled
   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_ready |=> s1_valid_ff && $stable(rd_data))
      else $error("staged read data lost during stall");

endmodule

@@ tb/sv/dab_time_deinterleaver_tb.sv @@
`timescale 1ns / 1ps

module dab_time_deinterleaver_tb;

   localparam int MAX_FRAG      = 8192;
   localparam int BRANCHES      = dabti_pkg::BRANCHES;
   localparam int VALUE_W       = dabti_pkg::VALUE_W;
   localparam int CFG_W         = dabti_pkg::CFG_W;
   // every row of the delay memory is filled at least this far before output starts
   localparam int FILL_SIZE     = 32;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 20;
   localparam int HOLD_OFF      = 300;
   localparam int RANDOM_ITEMS  = 700;
   localparam int CALM_TAIL     = 250;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } soft_out_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CFG_W-1:0]          csr_fragment_size;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [VALUE_W-1:0] req_soft_value;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [VALUE_W-1:0] rsp_deinterleaved_value;
   logic                      rsp_last_in_fragment;

   // shared control between the test sequence and the response side
   bit idle_on         = 1'b0;
   int hold_off_cycles = 0;
   int mismatch_count  = 0;
   int cycle_count     = 0;

   // predicted deinterleaver state
   logic [VALUE_W-1:0] branch_rows [0:BRANCHES*MAX_FRAG-1];
   logic [3:0]         cur_slot       = '0;
   logic [12:0]        frag_pos       = '0;
   logic [4:0]         fragments_done = '0;
   logic [CFG_W-1:0]   frag_size      = CFG_W'(dabti_pkg::CFG_RESET);
   soft_out_type       delayed_values_q [$];

   dab_time_deinterleaver #(
      .MAX_FRAGMENT(MAX_FRAG)
   ) DUT (
      .clock                   (clock),
      .reset                   (reset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_fragment_size       (csr_fragment_size),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_soft_value          (req_soft_value),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_deinterleaved_value (rsp_deinterleaved_value),
      .rsp_last_in_fragment    (rsp_last_in_fragment)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // One accepted request: read the delayed value, store the new one, advance
   function automatic void deinterleave_step(input logic [VALUE_W-1:0] sample);
      int                 eff_len;
      logic [3:0]         rd_slot;
      logic [VALUE_W-1:0] delayed;
      logic               ends;
      soft_out_type       res;
      if (frag_size == 0)
         eff_len = 1;
      else if (int'(frag_size) > MAX_FRAG)
         eff_len = MAX_FRAG;
      else
         eff_len = int'(frag_size);
      // branch delay index is the 4-bit bit reversal of the position
      rd_slot = cur_slot + {frag_pos[0], frag_pos[1], frag_pos[2], frag_pos[3]};
      delayed = branch_rows[{rd_slot, frag_pos}];
      ends    = (int'(frag_pos) + 1 >= eff_len);
      branch_rows[{cur_slot, frag_pos}] = sample;
      if (fragments_done >= 5'd16) begin
         res.value = delayed;
         res.last  = ends;
         delayed_values_q.push_back(res);
      end
      if (ends) begin
         frag_pos = '0;
         cur_slot = cur_slot + 4'd1;
         if (fragments_done < 5'd16)
            fragments_done = fragments_done + 5'd1;
      end else begin
         frag_pos = frag_pos + 13'd1;
      end
   endfunction

   function automatic logic [VALUE_W-1:0] pick_soft_value();
      case ($urandom_range(0, 15))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // Offer one request; valid stays up across back-to-back requests
   task automatic send_soft_value(input logic [VALUE_W-1:0] sample);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_soft_value <= sample;
      do @(posedge clock); while (!req_ready);
      deinterleave_step(sample);
   endtask

   task automatic send_random_values(input int count);
      repeat (count) send_soft_value(pick_soft_value());
   endtask

   // Drop valid, wait for outstanding responses, then let the pipeline empty
   task automatic settle_block();
      req_valid <= 1'b0;
      while (delayed_values_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_fragment_size(input logic [CFG_W-1:0] frag_len);
      csr_valid         <= 1'b1;
      csr_fragment_size <= frag_len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      frag_size = frag_len;
   endtask

   // Fill phase: oversized setting, low 13 bits alone would end the fragment at 50,
   // then all ones; the fragment runs on through both and a small size closes it
   task automatic test_fill_oversize();
      write_fragment_size(14'd8242);
      send_random_values(60);
      settle_block();
      write_fragment_size(14'h3FFF);
      send_random_values(10);
      settle_block();
      write_fragment_size(CFG_W'(FILL_SIZE));
      send_random_values(1);
      settle_block();
   endtask

   // Fill phase: shrink below the current position, then fill the remaining rows
   task automatic test_fill_lower_midfragment();
      write_fragment_size(CFG_W'(MAX_FRAG));
      send_random_values(40);
      settle_block();
      write_fragment_size(CFG_W'(FILL_SIZE));
      send_random_values(1 + 14 * FILL_SIZE);
      settle_block();
   endtask

   task automatic test_field_extremes();
      logic [VALUE_W-1:0] corner [12];
      corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE,
                 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h7FFE, 16'h8001};
      foreach (corner[i]) send_soft_value(corner[i]);
      settle_block();
   endtask

   // Zero acts as one: every value closes its own fragment
   task automatic test_size_zero();
      write_fragment_size('0);
      send_random_values(4);
      settle_block();
      write_fragment_size(14'd1);
      send_random_values(3);
      settle_block();
   endtask

   // Output phase: lowering under the current position ends the fragment on the next value
   task automatic test_lower_midfragment();
      write_fragment_size(CFG_W'(FILL_SIZE));
      send_random_values(20);
      settle_block();
      write_fragment_size(14'd10);
      send_random_values(6);
      settle_block();
   endtask

   // Receiver holds off long enough for the block to stall its request side
   task automatic test_receiver_hold();
      write_fragment_size(CFG_W'(FILL_SIZE));
      hold_off_cycles = HOLD_OFF;
      send_random_values(120);
      settle_block();
   endtask

   task automatic test_random_traffic();
      int               sent;
      int               burst;
      logic [CFG_W-1:0] frag_len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         idle_on = (sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 7))
            0: frag_len = '0;
            1: frag_len = 14'd1;
            2: frag_len = CFG_W'(FILL_SIZE);
            default: frag_len = CFG_W'($urandom_range(1, FILL_SIZE));
         endcase
         write_fragment_size(frag_len);
         burst = $urandom_range(1, 200);
         send_random_values(burst);
         sent += burst;
         settle_block();
      end
   endtask

   // Response side: random stalls, plus a long hold when a test asks for one
   initial begin : rsp_ready_driver
      int n;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare every accepted response with the oldest predicted one
   initial begin : rsp_checker
      soft_out_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (delayed_values_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response, expected none, got value %0d last %0b",
                        $time, rsp_deinterleaved_value, rsp_last_in_fragment);
            end else begin
               want = delayed_values_q.pop_front();
               if (rsp_deinterleaved_value !== want.value) begin
                  mismatch_count++;
                  $display("%0t: deinterleaved_value expected %0d, got %0d",
                           $time, want.value, rsp_deinterleaved_value);
               end
               if (rsp_last_in_fragment !== want.last) begin
                  mismatch_count++;
                  $display("%0t: last_in_fragment expected %0b, got %0b",
                           $time, want.last, rsp_last_in_fragment);
               end
            end
         end
      end
   end

   // Timeout
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : test_sequence
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_soft_value    <= '0;
      csr_valid         <= 1'b0;
      csr_fragment_size <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;

      test_fill_oversize();
      test_fill_lower_midfragment();
      test_field_extremes();
      test_size_zero();
      test_lower_midfragment();
      test_receiver_hold();
      test_random_traffic();

      idle_on = 1'b0;
      settle_block();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && delayed_values_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ dab_time_deinterleaver.f @@
hw/rtl/dabti_pkg.sv
hw/rtl/dabti_store.sv
hw/rtl/dab_time_deinterleaver.sv
tb/sv/dab_time_deinterleaver_tb.sv
